/* rtl/rspd_pkg.sv */
// shared types, constants and helpers for the rsp packet deframer
package rspd_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_ACK   = 8'h2B;
  localparam logic [7:0] CH_NACK  = 8'h2D;
  localparam logic [7:0] CH_INTR  = 8'h03;

  typedef enum logic [2:0] {
    EV_PAYLOAD = 3'd0,
    EV_ACCEPT  = 3'd1,
    EV_REJECT  = 3'd2,
    EV_INTR    = 3'd3,
    EV_STRAY   = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [7:0]  payload_byte;
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic [7:0]  computed_sum;
  } out_item_t;

  // classified event between front and back: data is payload byte or packet sum
  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  data;
  } ev_rec_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

/* rtl/rspd_front.sv */
// front end: byte classification, packet phase tracking and checksum
module rspd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  rspd_pkg::in_item_t item,
  output logic              ev_valid,
  output rspd_pkg::ev_rec_t  ev
);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_DISCARD = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CSUM_HI = 5'b01000,
    PH_CSUM_LO = 5'b10000
  } phase_t;

  phase_t         phase_r, phase_nxt;
  logic [7:0]     sum_r, sum_nxt;
  logic [3:0]     hi_r, hi_nxt;
  logic           hi_bad_r, hi_bad_nxt;
  rspd_pkg::hex_t hx;

  assign hx = rspd_pkg::hex_decode(item.rx_byte);

  always_comb begin
    phase_nxt  = phase_r;
    sum_nxt    = sum_r;
    hi_nxt     = hi_r;
    hi_bad_nxt = hi_bad_r;
    ev_valid   = 1'b0;
    ev.kind    = rspd_pkg::EV_PAYLOAD;
    ev.data    = 8'd0;
    if (accept) begin
      unique case (phase_r)
        PH_DISCARD: begin
          if (item.chunk_end) phase_nxt = PH_IDLE;
        end
        PH_PAYLOAD: begin
          if (item.rx_byte == rspd_pkg::CH_END) begin
            phase_nxt = PH_CSUM_HI;
          end else begin
            sum_nxt  = sum_r + item.rx_byte;
            ev_valid = 1'b1;
            ev.kind  = rspd_pkg::EV_PAYLOAD;
            ev.data  = item.rx_byte;
          end
        end
        PH_CSUM_HI: begin
          hi_bad_nxt = ~hx.ok;
          hi_nxt     = hx.val;
          phase_nxt  = PH_CSUM_LO;
        end
        PH_CSUM_LO: begin
          phase_nxt = PH_IDLE;
          ev_valid  = 1'b1;
          ev.data   = sum_r;
          if (hx.ok && !hi_bad_r && {hi_r, hx.val} == sum_r) begin
            ev.kind = rspd_pkg::EV_ACCEPT;
          end else begin
            ev.kind = rspd_pkg::EV_REJECT;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (item.rx_byte == rspd_pkg::CH_ACK || item.rx_byte == rspd_pkg::CH_NACK) begin
            // stray acks outside a packet are dropped
          end else if (item.rx_byte == rspd_pkg::CH_INTR) begin
            ev_valid = 1'b1;
            ev.kind  = rspd_pkg::EV_INTR;
          end else if (item.rx_byte == rspd_pkg::CH_START) begin
            sum_nxt    = 8'd0;
            hi_nxt     = 4'd0;
            hi_bad_nxt = 1'b0;
            phase_nxt  = PH_PAYLOAD;
          end else begin
            ev_valid = 1'b1;
            ev.kind  = rspd_pkg::EV_STRAY;
            // rest of the chunk is thrown away
            if (!item.chunk_end) phase_nxt = PH_DISCARD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      sum_r    <= 8'd0;
      hi_r     <= 4'd0;
      hi_bad_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      sum_r    <= sum_nxt;
      hi_r     <= hi_nxt;
      hi_bad_r <= hi_bad_nxt;
    end
  end

endmodule

/* rtl/rspd_fifo.sv */
// short event queue between front and back
module rspd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  rspd_pkg::ev_rec_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output rspd_pkg::ev_rec_t rd_data
);

  rspd_pkg::ev_rec_t             mem_r [rspd_pkg::FIFO_DEPTH];
  logic [rspd_pkg::FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [rspd_pkg::FIFO_CW-1:0]  count_r;
  logic                          do_wr, do_rd;

  assign full     = (count_r == rspd_pkg::FIFO_CW'(rspd_pkg::FIFO_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/rspd_back.sv */
// back end: result formatting, ack mode register and output register
module rspd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ev_valid,
  input  rspd_pkg::ev_rec_t   ev,
  output logic               ev_pop,
  input  logic               cfg_valid,
  input  logic               cfg_data,
  output logic               cfg_ready,
  input  logic               pop,
  output logic               empty,
  output rspd_pkg::out_item_t out_data
);

  logic                out_valid_r;
  rspd_pkg::out_item_t out_r, out_nxt;
  logic                ack_en_r;
  logic                load;
  logic                pos_reply;

  assign cfg_ready = 1'b1;
  assign load      = ev_valid && (!out_valid_r || pop);
  assign ev_pop    = load;
  assign empty     = ~out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    out_nxt            = '0;
    out_nxt.event_kind = ev.kind;
    pos_reply          = 1'b0;
    case (ev.kind)
      rspd_pkg::EV_PAYLOAD: begin
        out_nxt.payload_byte = ev.data;
      end
      rspd_pkg::EV_ACCEPT: begin
        out_nxt.computed_sum = ev.data;
        pos_reply            = 1'b1;
      end
      rspd_pkg::EV_REJECT: begin
        out_nxt.computed_sum = ev.data;
      end
      rspd_pkg::EV_INTR: begin
        pos_reply = 1'b1;
      end
      default: begin
      end
    endcase
    // every event but payload answers the host unless in no-ack mode
    if (ev.kind != rspd_pkg::EV_PAYLOAD && ack_en_r) begin
      out_nxt.reply_valid = 1'b1;
      out_nxt.reply_byte  = pos_reply ? rspd_pkg::CH_ACK : rspd_pkg::CH_NACK;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ack_en_r    <= 1'b1;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) ack_en_r <= cfg_data;
    end
  end

endmodule

/* rtl/rsp_packet_deframer.sv */
// top level of the rsp packet deframer
//
// Input side is a queue write port: a byte with its chunk-end flag is
// transferred when push is high and full is low. Results leave through a
// queue read port: while empty is low the oldest result sits on out_data
// and is transferred when pop is high. One event record (payload byte,
// packet accepted or rejected, interrupt, stray byte) leaves per byte at
// most; framing bytes and discarded bytes give none.
// The ack mode bit is written through cfg_valid/cfg_data; cfg_ready is
// always high. Write it only while no result is outstanding.
// Path: the front writes the event record into the event queue at the
// transfer edge; the output register loads it from the queue once that
// register is empty or being popped.
// Throughput: one byte per cycle while full is low; the front next-state
// logic and 8-bit checksum add are combinational.
// Reset: phase returns to idle outside any packet, the queue and output
// register empty, ack mode is on.
// Receiver stall: the four-entry event queue plus output register absorb
// results; full rises only once they are all occupied.
module rsp_packet_deframer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  rspd_pkg::in_item_t   in_data,
  input  logic                pop,
  output logic                empty,
  output rspd_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  logic              accept;
  logic              fr_valid;
  rspd_pkg::ev_rec_t fr_ev;
  logic              q_valid;
  rspd_pkg::ev_rec_t q_ev;
  logic              q_pop;

  assign accept = push && !full;

  rspd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_data),
    .ev_valid (fr_valid),
    .ev       (fr_ev)
  );

  rspd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fr_valid),
    .wr_data  (fr_ev),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_ev)
  );

  rspd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (q_valid),
    .ev        (q_ev),
    .ev_pop    (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data)
  );

endmodule

/* rtl/rspd_checker.sv */
// port-level checks for the rsp packet deframer, bound to the top level
module rspd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                pop,
  input logic                empty,
  input rspd_pkg::out_item_t  out_data
);

  // reset leaves nothing to read
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result waiting right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("result changed while stalled");

  // acknowledgement bytes are only plus or minus
  a_reply_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.reply_valid) |->
      (out_data.reply_byte == rspd_pkg::CH_ACK || out_data.reply_byte == rspd_pkg::CH_NACK))
    else $error("bad acknowledgement byte");

  // payload records carry no reply and no sum
  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.event_kind == rspd_pkg::EV_PAYLOAD) |->
      (!out_data.reply_valid && out_data.computed_sum == 8'd0))
    else $error("payload record carries reply or sum");

  // interrupt and stray records have zero payload and sum
  a_ctrl_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_data.event_kind == rspd_pkg::EV_INTR ||
                out_data.event_kind == rspd_pkg::EV_STRAY)) |->
      (out_data.payload_byte == 8'd0 && out_data.computed_sum == 8'd0))
    else $error("control record carries payload or sum");

endmodule

bind rsp_packet_deframer rspd_checker u_chk (.*);

/* bench/rsp_packet_deframer_tb.sv */
// self-checking testbench for the rsp packet deframer
module rsp_packet_deframer_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int ITEMS_PER_RUN  = 270;
  localparam int SETTLE_CYCLES  = 6;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DISCARD = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CSUM_HI = 3'd3,
    PH_CSUM_LO = 3'd4
  } frame_phase_t;

  typedef enum logic [1:0] {
    ROW_CHECK, // result taken from the predictor
    ROW_QUIET, // no result may come
    ROW_FIXED  // result typed in the table
  } row_kind_t;

  typedef struct packed {
    rspd_pkg::in_item_t  item;
    row_kind_t           kind;
    rspd_pkg::out_item_t ev;
  } row_t;

  localparam rspd_pkg::out_item_t NO_EVENT = '0;

  localparam row_t DIR_ROWS [27] = '{
    '{'{rspd_pkg::CH_ACK, 1'b1}, ROW_QUIET, NO_EVENT},
    '{'{rspd_pkg::CH_NACK, 1'b1}, ROW_QUIET, NO_EVENT},
    '{'{rspd_pkg::CH_INTR, 1'b1}, ROW_FIXED,
      '{rspd_pkg::EV_INTR, 8'h00, 1'b1, rspd_pkg::CH_ACK, 8'h00}},
    // stray byte mid-chunk, rest of the chunk is thrown away
    '{'{8'h00, 1'b0}, ROW_FIXED,
      '{rspd_pkg::EV_STRAY, 8'h00, 1'b1, rspd_pkg::CH_NACK, 8'h00}},
    '{'{8'hFF, 1'b0}, ROW_QUIET, NO_EVENT},
    '{'{rspd_pkg::CH_START, 1'b1}, ROW_QUIET, NO_EVENT},
    '{'{8'hFF, 1'b1}, ROW_FIXED,
      '{rspd_pkg::EV_STRAY, 8'h00, 1'b1, rspd_pkg::CH_NACK, 8'h00}},
    // empty packet
    '{'{rspd_pkg::CH_START, 1'b0}, ROW_QUIET, NO_EVENT},
    '{'{rspd_pkg::CH_END, 1'b0}, ROW_QUIET, NO_EVENT},
    '{'{8'h30, 1'b1}, ROW_QUIET, NO_EVENT},
    '{'{8'h30, 1'b0}, ROW_FIXED,
      '{rspd_pkg::EV_ACCEPT, 8'h00, 1'b1, rspd_pkg::CH_ACK, 8'h00}},
    // chunk ends inside a packet are ignored, '$' inside is payload
    '{'{rspd_pkg::CH_START, 1'b0}, ROW_QUIET, NO_EVENT},
    '{'{8'hFF, 1'b1}, ROW_FIXED, '{rspd_pkg::EV_PAYLOAD, 8'hFF, 1'b0, 8'h00, 8'h00}},
    '{'{8'h01, 1'b0}, ROW_FIXED, '{rspd_pkg::EV_PAYLOAD, 8'h01, 1'b0, 8'h00, 8'h00}},
    '{'{rspd_pkg::CH_START, 1'b0}, ROW_CHECK, NO_EVENT},
    '{'{rspd_pkg::CH_END, 1'b0}, ROW_QUIET, NO_EVENT},
    '{'{8'h32, 1'b0}, ROW_QUIET, NO_EVENT},
    '{'{8'h34, 1'b1}, ROW_FIXED,
      '{rspd_pkg::EV_ACCEPT, 8'h00, 1'b1, rspd_pkg::CH_ACK, 8'h24}},
    // wrong checksum
    '{'{rspd_pkg::CH_START, 1'b0}, ROW_QUIET, NO_EVENT},
    '{'{8'h61, 1'b0}, ROW_CHECK, NO_EVENT},
    '{'{rspd_pkg::CH_END, 1'b0}, ROW_QUIET, NO_EVENT},
    '{'{8'h36, 1'b0}, ROW_QUIET, NO_EVENT},
    '{'{8'h65, 1'b0}, ROW_FIXED,
      '{rspd_pkg::EV_REJECT, 8'h00, 1'b1, rspd_pkg::CH_NACK, 8'h61}},
    // non-hex first digit
    '{'{rspd_pkg::CH_START, 1'b0}, ROW_QUIET, NO_EVENT},
    '{'{rspd_pkg::CH_END, 1'b0}, ROW_QUIET, NO_EVENT},
    '{'{8'h67, 1'b0}, ROW_QUIET, NO_EVENT},
    '{'{8'h30, 1'b1}, ROW_FIXED,
      '{rspd_pkg::EV_REJECT, 8'h00, 1'b1, rspd_pkg::CH_NACK, 8'h00}}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  rspd_pkg::in_item_t  in_data = '0;
  logic                pop = 1'b0;
  logic                empty;
  rspd_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data = 1'b0;

  row_kind_t           row_mode = ROW_CHECK;
  rspd_pkg::out_item_t row_event = '0;

  // predictor state
  frame_phase_t fr_phase = PH_IDLE;
  logic [7:0]   pkt_sum = 8'h00;
  logic [3:0]   csum_hi = 4'h0;
  logic         csum_hi_bad = 1'b0;
  logic         ack_mode = 1'b1;

  rspd_pkg::out_item_t expected_events [$];
  rspd_pkg::in_item_t  frame_bytes [$];
  int                  error_count = 0;
  int                  quiet_cycles = 0;
  int                  tx_left = 0;
  bit                  tx_burst = 1'b0;
  bit                  hold_req = 1'b0;

  rsp_packet_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'd10);
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [3:0] v;
    do c = 8'($urandom_range(0, 255)); while (hex_nibble(c, v));
    return c;
  endfunction

  function automatic bit chunk_bit();
    return $urandom_range(0, 7) == 0;
  endfunction

  // appends one byte to the frame being built
  function automatic void add_byte(input rspd_pkg::in_item_t it);
    frame_bytes = {frame_bytes, it};
  endfunction

  function automatic int next_gap();
    if (tx_left == 0) begin
      tx_left = $urandom_range(8, 40);
      tx_burst = ($urandom_range(0, 3) == 0);
    end
    tx_left--;
    return tx_burst ? 0 : $urandom_range(0, 17);
  endfunction

  // advances the deframer state by one byte, returns 1 when a result is due
  function automatic bit deframe_byte(input rspd_pkg::in_item_t it,
                                      output rspd_pkg::out_item_t ev);
    logic [3:0] nib;
    logic [7:0] ack_byte;
    bit         hit;
    bit         good;
    ev = '0;
    hit = 1'b0;
    ack_byte = rspd_pkg::CH_ACK;
    case (fr_phase)
      PH_DISCARD: begin
        if (it.chunk_end) fr_phase = PH_IDLE;
      end
      PH_PAYLOAD: begin
        if (it.rx_byte == rspd_pkg::CH_END) begin
          fr_phase = PH_CSUM_HI;
        end else begin
          pkt_sum = pkt_sum + it.rx_byte;
          ev.event_kind = rspd_pkg::EV_PAYLOAD;
          ev.payload_byte = it.rx_byte;
          hit = 1'b1;
        end
      end
      PH_CSUM_HI: begin
        csum_hi_bad = !hex_nibble(it.rx_byte, nib);
        csum_hi = nib;
        fr_phase = PH_CSUM_LO;
      end
      PH_CSUM_LO: begin
        good = hex_nibble(it.rx_byte, nib) && !csum_hi_bad && ({csum_hi, nib} == pkt_sum);
        fr_phase = PH_IDLE;
        ev.event_kind = good ? rspd_pkg::EV_ACCEPT : rspd_pkg::EV_REJECT;
        ev.computed_sum = pkt_sum;
        ack_byte = good ? rspd_pkg::CH_ACK : rspd_pkg::CH_NACK;
        hit = 1'b1;
      end
      default: begin
        fr_phase = PH_IDLE;
        if (it.rx_byte == rspd_pkg::CH_INTR) begin
          ev.event_kind = rspd_pkg::EV_INTR;
          hit = 1'b1;
        end else if (it.rx_byte == rspd_pkg::CH_START) begin
          pkt_sum = 8'h00;
          csum_hi = 4'h0;
          csum_hi_bad = 1'b0;
          fr_phase = PH_PAYLOAD;
        end else if (it.rx_byte != rspd_pkg::CH_ACK && it.rx_byte != rspd_pkg::CH_NACK) begin
          if (!it.chunk_end) fr_phase = PH_DISCARD;
          ev.event_kind = rspd_pkg::EV_STRAY;
          ack_byte = rspd_pkg::CH_NACK;
          hit = 1'b1;
        end
      end
    endcase
    if (hit && ev.event_kind != rspd_pkg::EV_PAYLOAD && ack_mode) begin
      ev.reply_valid = 1'b1;
      ev.reply_byte = ack_byte;
    end
    return hit;
  endfunction

  // one byte sequence: mostly framed packets with random content
  task automatic build_frame(input int force_len);
    int         n;
    int         pick;
    logic [7:0] b;
    logic [7:0] sum;
    logic [7:0] hi_c;
    logic [7:0] lo_c;
    frame_bytes.delete();
    pick = (force_len >= 0) ? 0 : $urandom_range(0, 99);
    if (pick < 62) begin
      if (force_len >= 0) n = force_len;
      else n = ($urandom_range(0, 19) == 0) ? 40 : $urandom_range(0, 12);
      sum = 8'h00;
      add_byte(rspd_pkg::in_item_t'{rspd_pkg::CH_START, chunk_bit()});
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        if (b == rspd_pkg::CH_END) b = 8'h22;
        sum = sum + b;
        add_byte(rspd_pkg::in_item_t'{b, chunk_bit()});
      end
      add_byte(rspd_pkg::in_item_t'{rspd_pkg::CH_END, chunk_bit()});
      if (force_len < 0 && $urandom_range(0, 7) == 0) sum = sum ^ 8'(1 << $urandom_range(0, 7));
      hi_c = hex_char(sum[7:4], 1'($urandom_range(0, 1)));
      lo_c = hex_char(sum[3:0], 1'($urandom_range(0, 1)));
      if (force_len < 0) begin
        case ($urandom_range(0, 9))
          0: hi_c = non_hex_char();
          1: lo_c = non_hex_char();
          default: ;
        endcase
      end
      add_byte(rspd_pkg::in_item_t'{hi_c, chunk_bit()});
      add_byte(rspd_pkg::in_item_t'{lo_c, chunk_bit()});
    end else if (pick < 72) begin
      add_byte(rspd_pkg::in_item_t'{$urandom_range(0, 1) ? rspd_pkg::CH_ACK : rspd_pkg::CH_NACK,
                                    chunk_bit()});
    end else if (pick < 80) begin
      add_byte(rspd_pkg::in_item_t'{rspd_pkg::CH_INTR, chunk_bit()});
    end else if (pick < 90) begin
      do b = 8'($urandom_range(0, 255));
      while (b inside {rspd_pkg::CH_ACK, rspd_pkg::CH_NACK, rspd_pkg::CH_INTR,
                       rspd_pkg::CH_START});
      if ($urandom_range(0, 3) == 0) begin
        add_byte(rspd_pkg::in_item_t'{b, 1'b1});
      end else begin
        add_byte(rspd_pkg::in_item_t'{b, 1'b0});
        repeat ($urandom_range(0, 4))
          add_byte(rspd_pkg::in_item_t'{8'($urandom_range(0, 255)), 1'b0});
        add_byte(rspd_pkg::in_item_t'{8'($urandom_range(0, 255)), 1'b1});
      end
    end else begin
      repeat ($urandom_range(1, 3))
        add_byte(rspd_pkg::in_item_t'{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))});
    end
  endtask

  task automatic send_item(input rspd_pkg::in_item_t it, input row_kind_t kind,
                           input rspd_pkg::out_item_t ev, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    in_data <= it;
    row_mode <= kind;
    row_event <= ev;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // stop offering and wait until every expected result has come out
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : monitor_blk
    rspd_pkg::out_item_t ev;
    rspd_pkg::out_item_t want;
    bit                  produced;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) ack_mode = cfg_data;
      if (push && !full) begin
        produced = deframe_byte(in_data, ev);
        case (row_mode)
          ROW_FIXED: expected_events = {expected_events, row_event};
          ROW_CHECK: if (produced) expected_events = {expected_events, ev};
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
          error_count++;
        end else begin
          want = expected_events.pop_front();
          if (out_data.event_kind !== want.event_kind) begin
            $display("%0t: event_kind expected %0d, got %0d", $time, want.event_kind,
                     out_data.event_kind);
            error_count++;
          end
          if (out_data.payload_byte !== want.payload_byte) begin
            $display("%0t: payload_byte expected %h, got %h", $time, want.payload_byte,
                     out_data.payload_byte);
            error_count++;
          end
          if (out_data.reply_valid !== want.reply_valid) begin
            $display("%0t: reply_valid expected %b, got %b", $time, want.reply_valid,
                     out_data.reply_valid);
            error_count++;
          end
          if (out_data.reply_byte !== want.reply_byte) begin
            $display("%0t: reply_byte expected %h, got %h", $time, want.reply_byte,
                     out_data.reply_byte);
            error_count++;
          end
          if (out_data.computed_sum !== want.computed_sum) begin
            $display("%0t: computed_sum expected %h, got %h", $time, want.computed_sum,
                     out_data.computed_sum);
            error_count++;
          end
        end
      end
    end
  end

  // no transfer of any kind for too long means the block has hung
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_side
    int  gap;
    int  rx_left;
    bit  rx_burst;
    rx_left = 0;
    rx_burst = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end
      if (rx_left == 0) begin
        rx_left = $urandom_range(8, 40);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      rx_left--;
      gap = rx_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  initial begin : stimulus
    int sent;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    foreach (DIR_ROWS[i])
      send_item(DIR_ROWS[i].item, DIR_ROWS[i].kind, DIR_ROWS[i].ev, next_gap());
    for (int p = 0; p < 4; p++) begin
      settle();
      // ack mode alternates off and on
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_data <= p[0];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
      cfg_valid <= 1'b0;
      if (p == 1) begin
        // result side stalls while a long packet is pushed back to back
        hold_req = 1'b1;
        build_frame(24);
        foreach (frame_bytes[j]) send_item(frame_bytes[j], ROW_CHECK, NO_EVENT, 0);
      end
      sent = 0;
      while (sent < ITEMS_PER_RUN) begin
        build_frame(-1);
        foreach (frame_bytes[j]) begin
          send_item(frame_bytes[j], ROW_CHECK, NO_EVENT, next_gap());
          sent++;
        end
      end
    end
    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rspd_pkg.sv
rtl/rspd_front.sv
rtl/rspd_fifo.sv
rtl/rspd_back.sv
rtl/rsp_packet_deframer.sv
rtl/rspd_checker.sv
bench/rsp_packet_deframer_tb.sv
